>>> design/crc8rf_pkg.sv
// shared types, constants and crc step function for the reply frame checker
package crc8rf_pkg;

	localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1024;
	localparam logic [15:0] PAYLOAD_FIRST     = 16'd6;
	localparam logic [15:0] HOLD_DEPTH        = 16'd2;
	localparam logic [7:0]  CRC_POLY_REFL     = 8'h8c;

	localparam int QDEPTH = 3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        frame_ok;
		logic [15:0] payload_count;
		logic        run_end;
	} out_word_t;

	typedef struct packed {
		logic [1:0] num;
		out_word_t  first;
		out_word_t  second;
	} qpush_t;

	typedef struct packed {
		logic not_empty;
		logic near_full;
	} qstat_t;

	// one table step of crc-8/maxim (reflected 0x31)
	function automatic logic [7:0] crc_step(input logic [7:0] idx);
		logic [7:0] c;
		c = idx;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> design/crc8rf_outq.sv
// three-word result queue, up to two words pushed and one popped per cycle
module crc8rf_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crc8rf_pkg::qpush_t    push,
	input  logic                  pop,
	output crc8rf_pkg::out_word_t head,
	output crc8rf_pkg::qstat_t    stat
);

	crc8rf_pkg::out_word_t ent_q [crc8rf_pkg::QDEPTH];
	crc8rf_pkg::out_word_t ent_d [crc8rf_pkg::QDEPTH];
	logic [1:0] count_q;
	logic [1:0] count_d;
	logic [1:0] base;

	always_comb begin
		ent_d = ent_q;
		base  = count_q;
		if (pop) begin
			for (int i = 0; i < crc8rf_pkg::QDEPTH - 1; i++) begin
				ent_d[i] = ent_q[i + 1];
			end
			base = count_q - 2'd1;
		end
		for (int i = 0; i < crc8rf_pkg::QDEPTH; i++) begin
			if (push.num != 2'd0 && 2'(i) == base) begin
				ent_d[i] = push.first;
			end
			if (push.num == 2'd2 && 2'(i) == base + 2'd1) begin
				ent_d[i] = push.second;
			end
		end
		count_d = base + push.num;
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	assign head           = ent_q[0];
	assign stat.not_empty = (count_q != 2'd0);
	assign stat.near_full = (count_q >= 2'd2);

endmodule

>>> design/crc8_reply_frame_checker.sv
// top level of the crc-8/maxim reply frame checker
// Takes one frame byte per clock while in_stall is low. Each accepted word updates
// the crc, the two-byte hold line and the counters in the same cycle and pushes its
// zero, one or two results into a three-word result queue, whose registers feed the
// output. The input stalls while two or more results wait, so a byte that gives both
// a payload byte and the verdict stalls it until one drains. The max_frame_len
// register (reset value 1024) is written through cfg_we and cfg_wdata; the user must
// write it only while no frame is in progress, which the block does not enforce.
module crc8_reply_frame_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  crc8rf_pkg::in_word_t  in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output crc8rf_pkg::out_word_t out_word
);

	logic [15:0] max_frame_len_q;
	logic [7:0]  crc_q;
	logic [7:0]  older_q;
	logic [7:0]  newer_q;
	logic [15:0] byte_cnt_q;
	logic [15:0] payload_cnt_q;

	logic [7:0]  crc_d;
	logic [7:0]  older_d;
	logic [7:0]  newer_d;
	logic [15:0] byte_cnt_d;
	logic [15:0] payload_cnt_d;

	logic keep, fold, emit_pl, accept, ok;
	crc8rf_pkg::out_word_t pl_word, vd_word;
	crc8rf_pkg::qpush_t    push;
	crc8rf_pkg::qstat_t    stat;

	assign accept = in_valid && !in_stall;

	always_comb begin
		keep    = (byte_cnt_q < max_frame_len_q);
		fold    = keep && (byte_cnt_q >= crc8rf_pkg::HOLD_DEPTH);
		emit_pl = keep && (byte_cnt_q >= crc8rf_pkg::HOLD_DEPTH + crc8rf_pkg::PAYLOAD_FIRST);

		crc_d         = fold ? crc8rf_pkg::crc_step(crc_q ^ older_q) : crc_q;
		older_d       = keep ? newer_q : older_q;
		newer_d       = keep ? in_word.byte_in : newer_q;
		byte_cnt_d    = keep ? byte_cnt_q + 16'd1 : byte_cnt_q;
		payload_cnt_d = emit_pl ? payload_cnt_q + 16'd1 : payload_cnt_q;

		ok = (byte_cnt_d >= crc8rf_pkg::HOLD_DEPTH) && (older_d == crc_d);

		pl_word.kind          = crc8rf_pkg::KIND_PAYLOAD;
		pl_word.payload_byte  = older_q;
		pl_word.frame_ok      = 1'b0;
		pl_word.payload_count = 16'd0;
		pl_word.run_end       = !in_word.frame_end;

		vd_word.kind          = crc8rf_pkg::KIND_VERDICT;
		vd_word.payload_byte  = 8'd0;
		vd_word.frame_ok      = ok;
		vd_word.payload_count = payload_cnt_d;
		vd_word.run_end       = 1'b1;

		push.num    = 2'd0;
		push.first  = pl_word;
		push.second = vd_word;
		if (accept) begin
			if (emit_pl && in_word.frame_end) begin
				push.num = 2'd2;
			end else if (emit_pl) begin
				push.num = 2'd1;
			end else if (in_word.frame_end) begin
				push.num   = 2'd1;
				push.first = vd_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= crc8rf_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_we) begin
			max_frame_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q         <= 8'd0;
			older_q       <= 8'd0;
			newer_q       <= 8'd0;
			byte_cnt_q    <= 16'd0;
			payload_cnt_q <= 16'd0;
		end else if (accept) begin
			if (in_word.frame_end) begin
				crc_q         <= 8'd0;
				older_q       <= 8'd0;
				newer_q       <= 8'd0;
				byte_cnt_q    <= 16'd0;
				payload_cnt_q <= 16'd0;
			end else begin
				crc_q         <= crc_d;
				older_q       <= older_d;
				newer_q       <= newer_d;
				byte_cnt_q    <= byte_cnt_d;
				payload_cnt_q <= payload_cnt_d;
			end
		end
	end

	crc8rf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_valid && !out_stall),
		.head   (out_word),
		.stat   (stat)
	);

	assign out_valid = stat.not_empty;
	assign in_stall  = stat.near_full;

endmodule

>>> verif/tb_crc8_reply_frame_checker.sv
// self-checking testbench for the crc-8/maxim reply frame checker with a frame-level scoreboard
`timescale 1ns / 1ps

module tb_crc8_reply_frame_checker;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 150;
	localparam int HOLD_CYCLES = 300;

	class frame_verdict_board;
		logic [15:0] max_len;
		logic [7:0]  crc_run;
		logic [7:0]  tail_prev;
		logic [7:0]  tail_last;
		logic [15:0] kept;
		logic [15:0] emitted;
		crc8rf_pkg::out_word_t expected_words[$];
		int          fails;

		function new();
			max_len = crc8rf_pkg::MAX_FRAME_LEN_RST;
			fails = 0;
			restart();
		endfunction

		function void restart();
			crc_run = 8'h00;
			tail_prev = 8'h00;
			tail_last = 8'h00;
			kept = 16'd0;
			emitted = 16'd0;
		endfunction

		// bit-serial crc-8/maxim, lsb first
		function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] b);
			logic [7:0] c;
			logic fb;
			c = acc;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb)
					c = c ^ crc8rf_pkg::CRC_POLY_REFL;
			end
			return c;
		endfunction

		function void take_byte(crc8rf_pkg::in_word_t w);
			crc8rf_pkg::out_word_t produced[$];
			crc8rf_pkg::out_word_t r;
			if (kept < max_len) begin
				if (kept >= 16'd2) begin
					crc_run = crc_next(crc_run, tail_prev);
					if (kept - 16'd2 >= crc8rf_pkg::PAYLOAD_FIRST) begin
						r = '0;
						r.kind = crc8rf_pkg::KIND_PAYLOAD;
						r.payload_byte = tail_prev;
						produced.push_back(r);
						emitted = emitted + 16'd1;
					end
				end
				tail_prev = tail_last;
				tail_last = w.byte_in;
				kept = kept + 16'd1;
			end
			if (w.frame_end) begin
				r = '0;
				r.kind = crc8rf_pkg::KIND_VERDICT;
				r.frame_ok = (kept >= 16'd2) && (tail_prev == crc_run);
				r.payload_count = emitted;
				produced.push_back(r);
				restart();
			end
			foreach (produced[i]) begin
				r = produced[i];
				r.run_end = (i == produced.size() - 1);
				expected_words.push_back(r);
			end
		endfunction

		task report(string msg);
			fails++;
			$display("mismatch: %s", msg);
		endtask

		task match_word(crc8rf_pkg::out_word_t got);
			crc8rf_pkg::out_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("word %h with nothing expected", got));
				return;
			end
			want = expected_words.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %b, want %b", got.kind, want.kind));
			if (got.payload_byte !== want.payload_byte)
				report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
			if (got.frame_ok !== want.frame_ok)
				report($sformatf("frame_ok %b, want %b", got.frame_ok, want.frame_ok));
			if (got.payload_count !== want.payload_count)
				report($sformatf("payload_count %0d, want %0d", got.payload_count,
					want.payload_count));
			if (got.run_end !== want.run_end)
				report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
		endtask

		task close_out();
			if (expected_words.size() != 0)
				report($sformatf("%0d words never arrived", expected_words.size()));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	crc8rf_pkg::in_word_t  in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	crc8rf_pkg::out_word_t out_word;

	logic        hold_req = 1'b0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          words_sent = 0;

	frame_verdict_board sb = new();

	crc8_reply_frame_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("tb_crc8_reply_frame_checker NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(in_word);
			if (out_valid && !out_stall)
				sb.match_word(out_word);
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		int seg;
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(10, 60);
			repeat (seg) begin
				@(posedge clk);
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req <= 1'b0;
				end
				case (mode)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 3) == 0);
					end
					2: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						out_stall <= ~out_stall;
					end
				endcase
			end
		end
	end

	task automatic send_word(crc8rf_pkg::in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// crc byte placed at the second-to-last kept position when fix_crc is on and at least two bytes are kept
	task automatic send_frame(int len, bit fix_crc, bit corrupt, bit extremes);
		logic [7:0] data [];
		logic [7:0] acc;
		int keep;
		crc8rf_pkg::in_word_t w;
		data = new[len];
		for (int i = 0; i < len; i++)
			data[i] = extremes ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom);
		keep = (len < sb.max_len) ? len : int'(sb.max_len);
		if (fix_crc && keep >= 2) begin
			acc = 8'h00;
			for (int i = 0; i < keep - 2; i++)
				acc = sb.crc_next(acc, data[i]);
			data[keep - 2] = acc;
			if (corrupt)
				data[keep - 2] = data[keep - 2] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (int i = 0; i < len; i++) begin
			w.byte_in = data[i];
			w.frame_end = (i == len - 1);
			send_word(w);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_len(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.max_len = v;
	endtask

	initial begin
		logic [15:0] phase_len [8];
		int start;
		int len;
		int pick;
		bit hold_done;
		phase_len = '{16'd2, 16'd9, 16'd65535, 16'd1, 16'd7, 16'd0, 16'd300, 16'd12};
		phase_len[5] = 16'($urandom_range(3, 40));
		hold_done = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames, empty crc, corrupted crc, payload plus verdict on one word
		send_frame(1, 1'b1, 1'b0, 1'b1);
		send_frame(1, 1'b0, 1'b0, 1'b0);
		send_frame(2, 1'b1, 1'b0, 1'b1);
		send_frame(2, 1'b1, 1'b1, 1'b0);
		send_frame(10, 1'b1, 1'b0, 1'b1);
		send_frame(9, 1'b1, 1'b1, 1'b1);
		drain();
		// dropped words, the last one carrying the frame end
		write_max_len(16'd1);
		send_frame(3, 1'b1, 1'b0, 1'b0);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_max_len(phase_len[p]);
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if (p == 2 && !hold_done && words_sent - start > 40) begin
					hold_req <= 1'b1;
					hold_done = 1'b1;
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) :
					$urandom_range(1, 24);
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_frame(len, 1'b1, 1'b0, 1'b0);
				else if (pick < 9)
					send_frame(len, 1'b1, 1'b1, 1'b0);
				else
					send_frame(len, 1'b0, 1'b0, 1'b0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		sb.close_out();
		if (sb.fails == 0)
			$display("tb_crc8_reply_frame_checker OK");
		else
			$display("tb_crc8_reply_frame_checker NOT OK");
		$finish;
	end

endmodule
